[sv/bsp_pkg.sv]
// Shared types and constants for the B-spline path stepper.
// No dependencies; the path stepper imports this package.
package bsp_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int POINT_W = 89;
   localparam int MUL_W   = 32;
   localparam int PROD_W  = 2 * MUL_W;

   // floor(n/3) as (n * DIV3_MAGIC) >> MUL_W, valid for 0 <= n < 2^31
   localparam logic signed [MUL_W-1:0] DIV3_MAGIC = 32'sd1431655766;
   localparam int QBIAS_EXP = 29;

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_RESTART = 2'd1,
      OP_STEP    = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_WGT,
      ST_WSET,
      ST_MIX,
      ST_INC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic signed [7:0]  roll;
      logic [15:0]        view_angle;
      logic [15:0]        frame_count;
      logic               end_mark;
   } point_type;

   localparam point_type PAST_POINT = '{
      pos_x: 16'sd0, pos_y: 16'sd0, pos_z: 16'sd0, roll: 8'sd0,
      view_angle: 16'd0, frame_count: 16'd0, end_mark: 1'b1
   };

endpackage

[sv/bsp_ifs.sv]
// Valid/ready channel interfaces for the path stepper: request and response.
// No dependencies.
interface bsp_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic [5:0]         point_index;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic signed [15:0] pos_z;
   logic signed [7:0]  roll_in;
   logic [15:0]        view_angle;
   logic [15:0]        frame_count;
   logic               end_mark;

   modport source (output valid, op, point_index, pos_x, pos_y, pos_z, roll_in,
                   view_angle, frame_count, end_mark, input ready);
   modport sink   (input valid, op, point_index, pos_x, pos_y, pos_z, roll_in,
                   view_angle, frame_count, end_mark, output ready);
endinterface

interface bsp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] out_x;
   logic signed [23:0] out_y;
   logic signed [23:0] out_z;
   logic signed [15:0] out_roll;
   logic [15:0]        out_angle;
   logic               position_valid;
   logic               path_done;

   modport source (output valid, out_x, out_y, out_z, out_roll, out_angle,
                   position_valid, path_done, input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_roll, out_angle,
                   position_valid, path_done, output ready);
endinterface

[sv/bsp_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/bspline_path_stepper.sv]
// Uniform cubic B-spline path stepper over a control point table in RAM.
// A step beat does up to five RAM reads, then 30 products on one shared
// 32x32 multiplier; the two reciprocals run on a radix-2 divider meanwhile.
// A step that meets an end mark in its first three points skips the products.
// Sync reset clears cursor, fraction, FSM and response valid; RAM is not cleared.
module bspline_path_stepper import bsp_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   bsp_req_if.sink   req_ch,
   bsp_rsp_if.source rsp_ch
);

   localparam int IW  = $clog2(MAX_POINTS);
   localparam int WW  = FRAC_BITS + 4;
   localparam int VW  = FRAC_BITS + 23;
   localparam int SW  = VW + 8;
   localparam int NW  = SW - (FRAC_BITS + 1);
   localparam int DW  = (FRAC_BITS > 15 ? FRAC_BITS : 15) + 1;
   localparam int DCW = $clog2(DW + 1);
   localparam int RW  = FRAC_BITS + 1;
   localparam int DFW = FRAC_BITS + 2;
   localparam int NCW = FRAC_BITS + 3;

   localparam logic [FRAC_BITS:0]          UNIT     = (FRAC_BITS+1)'(1) << FRAC_BITS;
   localparam logic signed [SW-1:0]        ROUND_OF = SW'(3) <<< FRAC_BITS;
   localparam logic signed [MUL_W-1:0]     NQ_BIAS  = MUL_W'(3) <<< QBIAS_EXP;
   localparam logic signed [30:0]          Q_BIAS   = 31'sd1 <<< QBIAS_EXP;

   state_type state_ff, state_in;

   logic [IW-1:0]        cursor_ff;
   logic [FRAC_BITS-1:0] frac_ff;
   logic [2:0]           rd_cnt_ff;
   logic                 past_ff;
   point_type            pt_ff [5];
   logic                 half_ff;
   logic [1:0]           wcnt_ff;
   logic [2:0]           chan_ff;
   logic [2:0]           tap_ff;
   logic [FRAC_BITS:0]   x2_ff, x3_ff, i2_ff, i3_ff;
   logic signed [WW-1:0] w_ff [4];
   logic signed [VW-1:0] acc_ff;
   logic signed [PROD_W-1:0] prod_ff;

   logic                 div_busy_ff;
   logic [DCW-1:0]       dcnt_ff;
   logic [DW-1:0]        dnum_ff [2];
   logic [16:0]          drem_ff [2];
   logic [DW-1:0]        dq_ff   [2];

   logic signed [23:0] res_x_ff, res_y_ff, res_z_ff;
   logic signed [15:0] res_roll_ff;
   logic [15:0]        res_angle_ff;
   logic               res_valid_ff, res_done_ff;

   logic               rsp_valid_ff;
   logic signed [23:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic signed [15:0] rsp_roll_ff;
   logic [15:0]        rsp_angle_ff;
   logic               rsp_pv_ff, rsp_done_ff;

   // request side
   logic      req_fire;
   op_type    req_op;
   logic      ram_we;
   point_type wr_point;
   logic [IW:0]        rd_sum;
   logic               rd_past;
   logic               ram_re;
   logic [POINT_W-1:0] ram_rd_data;
   logic [2:0]         cap_idx;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_op       = op_type'(req_ch.op);
   assign ram_we       = req_fire && (req_op == OP_WRITE) &&
                         (32'(req_ch.point_index) < MAX_POINTS);
   assign wr_point     = '{pos_x: req_ch.pos_x, pos_y: req_ch.pos_y, pos_z: req_ch.pos_z,
                           roll: req_ch.roll_in, view_angle: req_ch.view_angle,
                           frame_count: req_ch.frame_count, end_mark: req_ch.end_mark};
   assign rd_sum       = {1'b0, cursor_ff} + (IW+1)'(rd_cnt_ff);
   assign rd_past      = (rd_sum >= (IW+1)'(MAX_POINTS));
   assign ram_re       = (state_ff == ST_READ) && (rd_cnt_ff < 3'd5) && !rd_past;
   assign cap_idx      = rd_cnt_ff - 3'd1;

   bsp_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (IW'(req_ch.point_index)),
      .wr_data (wr_point),
      .rd_en   (ram_re),
      .rd_addr (rd_sum[IW-1:0]),
      .rd_data (ram_rd_data)
   );

   // shared multiplier operands
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_in;
   logic                     mul_go;
   logic [FRAC_BITS:0]       i_val;
   logic signed [16:0]       val_s;
   logic signed [SW-1:0]     sc, sc_b, nsh;
   logic signed [NW-1:0]     nval;
   logic [RW-1:0]            r1, r2;
   logic signed [DFW-1:0]    rdiff;
   point_type                tap_pt;

   assign i_val  = UNIT - {1'b0, frac_ff};
   assign tap_pt = pt_ff[tap_ff];
   assign r1     = (pt_ff[1].frame_count == 16'd0) ? '0 : dq_ff[0][RW-1:0];
   assign r2     = (pt_ff[2].frame_count == 16'd0) ? '0 : dq_ff[1][RW-1:0];
   assign rdiff  = $signed({1'b0, r2}) - $signed({1'b0, r1});

   always_comb begin
      case (chan_ff)
         3'd0:    val_s = 17'(tap_pt.pos_x);
         3'd1:    val_s = 17'(tap_pt.pos_y);
         3'd2:    val_s = 17'(tap_pt.pos_z);
         3'd3:    val_s = 17'(tap_pt.roll);
         default: val_s = $signed({1'b0, tap_pt.view_angle});
      endcase
      // positions and roll go to Q.8, the angle already is
      sc   = (chan_ff == 3'd4) ? SW'(acc_ff) : (SW'(acc_ff) <<< 8);
      sc_b = sc + ROUND_OF;
      nsh  = sc_b >>> (FRAC_BITS + 1);
      nval = nsh[NW-1:0];

      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_WGT: begin
            case (wcnt_ff)
               2'd0: begin mul_a = MUL_W'(frac_ff); mul_b = MUL_W'(frac_ff); end
               2'd1: begin mul_a = MUL_W'(x2_ff);   mul_b = MUL_W'(frac_ff); end
               2'd2: begin mul_a = MUL_W'(i_val);   mul_b = MUL_W'(i_val);   end
               default: begin mul_a = MUL_W'(i2_ff); mul_b = MUL_W'(i_val); end
            endcase
         end
         ST_MIX: begin
            if (tap_ff == 3'd4) begin
               mul_a = MUL_W'(nval) + NQ_BIAS;
               mul_b = DIV3_MAGIC;
            end else begin
               mul_a = MUL_W'(w_ff[tap_ff[1:0]]);
               mul_b = MUL_W'(val_s);
            end
         end
         ST_INC: begin
            mul_a = MUL_W'(frac_ff);
            mul_b = MUL_W'(rdiff);
         end
         default: ;
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign mul_go  = !half_ff && ((state_ff == ST_WGT) || (state_ff == ST_MIX) ||
                    ((state_ff == ST_INC) && !div_busy_ff));

   // divide-by-3 result and saturation
   logic signed [30:0] q_s;
   logic signed [23:0] sat24;
   logic signed [15:0] sat16;
   logic [15:0]        satu;

   always_comb begin
      q_s = $signed({1'b0, prod_ff[MUL_W +: 30]}) - Q_BIAS;
      if (q_s > 31'sd8388607)       sat24 = 24'sh7FFFFF;
      else if (q_s < -31'sd8388608) sat24 = 24'sh800000;
      else                          sat24 = q_s[23:0];
      if (q_s > 31'sd32767)         sat16 = 16'sh7FFF;
      else if (q_s < -31'sd32768)   sat16 = 16'sh8000;
      else                          sat16 = q_s[15:0];
      if (q_s < 31'sd0)             satu = 16'd0;
      else if (q_s > 31'sd65535)    satu = 16'hFFFF;
      else                          satu = q_s[15:0];
   end

   // weights, times six, from the powers of x and 1-x
   logic signed [WW-1:0] x_s, x2_s, x3_s, u_s;
   logic signed [WW-1:0] w_in [4];

   always_comb begin
      x_s  = WW'(frac_ff);
      x2_s = WW'(x2_ff);
      x3_s = WW'(x3_ff);
      u_s  = WW'(UNIT);
      w_in[0] = WW'(i3_ff);
      w_in[1] = WW'(x3_s * 3 - x2_s * 6 + u_s * 4);
      w_in[2] = WW'(x2_s * 3 - x3_s * 3 + x_s * 3 + u_s);
      w_in[3] = x3_s;
   end

   // fraction advance
   logic signed [NCW-1:0] inc_t, inc;
   logic signed [NCW:0]   nf, nf2;
   logic                  seg_end;
   logic [IW:0]           cur_inc;

   always_comb begin
      inc_t   = NCW'(prod_ff >>> FRAC_BITS);
      inc     = $signed(NCW'(r1)) + inc_t;
      nf      = (inc < 0) ? $signed((NCW+1)'(frac_ff))
                          : $signed((NCW+1)'(frac_ff)) + (NCW+1)'(inc);
      seg_end = (nf >= $signed((NCW+1)'(UNIT)));
      nf2     = seg_end ? nf - $signed((NCW+1)'(UNIT)) : nf;
      cur_inc = {1'b0, cursor_ff} + (IW+1)'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire && req_op == OP_STEP) state_in = ST_READ;
         ST_READ:   if (rd_cnt_ff == 3'd5) state_in = ST_CHECK;
         ST_CHECK: begin
            if (pt_ff[0].end_mark || pt_ff[1].end_mark || pt_ff[2].end_mark) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_WGT;
            end
         end
         ST_WGT:    if (half_ff && wcnt_ff == 2'd3) state_in = ST_WSET;
         ST_WSET:   state_in = ST_MIX;
         ST_MIX:    if (half_ff && tap_ff == 3'd4 && chan_ff == 3'd4) state_in = ST_INC;
         ST_INC:    if (half_ff) state_in = ST_FINISH;
         ST_FINISH: if (!rsp_valid_ff || rsp_ch.ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // cursor and fraction
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         frac_ff   <= '0;
      end else if (req_fire && req_op == OP_RESTART) begin
         cursor_ff <= '0;
         frac_ff   <= '0;
      end else if (state_ff == ST_INC && half_ff) begin
         if (seg_end) begin
            if (pt_ff[4].end_mark || cur_inc == (IW+1)'(MAX_POINTS)) begin
               cursor_ff <= '0;
            end else begin
               cursor_ff <= cur_inc[IW-1:0];
            end
         end
         if (nf2 >= $signed((NCW+1)'(UNIT))) begin
            frac_ff <= FRAC_BITS'(UNIT - 1'b1);
         end else begin
            frac_ff <= nf2[FRAC_BITS-1:0];
         end
      end
   end

   // datapath sequencing
   always_ff @(posedge clock) begin
      if (mul_go) begin
         prod_ff <= prod_in;
      end
      case (state_ff)
         ST_IDLE: begin
            rd_cnt_ff <= '0;
         end
         ST_READ: begin
            past_ff   <= rd_past;
            rd_cnt_ff <= rd_cnt_ff + 3'd1;
            if (rd_cnt_ff != 3'd0) begin
               pt_ff[cap_idx] <= past_ff ? PAST_POINT : point_type'(ram_rd_data);
            end
         end
         ST_CHECK: begin
            half_ff      <= 1'b0;
            wcnt_ff      <= '0;
            res_x_ff     <= '0;
            res_y_ff     <= '0;
            res_z_ff     <= '0;
            res_roll_ff  <= '0;
            res_angle_ff <= '0;
            res_valid_ff <= 1'b0;
            res_done_ff  <= 1'b1;
         end
         ST_WGT: begin
            half_ff <= !half_ff;
            if (half_ff) begin
               wcnt_ff <= wcnt_ff + 2'd1;
               case (wcnt_ff)
                  2'd0:    x2_ff <= prod_ff[FRAC_BITS +: FRAC_BITS+1];
                  2'd1:    x3_ff <= prod_ff[FRAC_BITS +: FRAC_BITS+1];
                  2'd2:    i2_ff <= prod_ff[FRAC_BITS +: FRAC_BITS+1];
                  default: i3_ff <= prod_ff[FRAC_BITS +: FRAC_BITS+1];
               endcase
            end
         end
         ST_WSET: begin
            w_ff    <= w_in;
            chan_ff <= '0;
            tap_ff  <= '0;
            half_ff <= 1'b0;
         end
         ST_MIX: begin
            half_ff <= !half_ff;
            if (half_ff) begin
               if (tap_ff == 3'd4) begin
                  tap_ff  <= '0;
                  chan_ff <= chan_ff + 3'd1;
                  case (chan_ff)
                     3'd0:    res_x_ff     <= sat24;
                     3'd1:    res_y_ff     <= sat24;
                     3'd2:    res_z_ff     <= sat24;
                     3'd3:    res_roll_ff  <= sat16;
                     default: res_angle_ff <= satu;
                  endcase
               end else begin
                  tap_ff <= tap_ff + 3'd1;
                  acc_ff <= ((tap_ff == 3'd0) ? '0 : acc_ff) + VW'(prod_ff);
               end
            end
         end
         ST_INC: begin
            if (mul_go) begin
               half_ff <= 1'b1;
            end
            if (half_ff) begin
               res_valid_ff <= 1'b1;
               res_done_ff  <= seg_end && pt_ff[4].end_mark;
            end
         end
         default: ;
      endcase
   end

   // reciprocal divider, two lanes, one quotient bit per cycle
   logic [16:0] rem_sh [2];
   logic        rem_ge [2];

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         rem_sh[j] = {drem_ff[j][15:0], dnum_ff[j][DW-1]};
         rem_ge[j] = (rem_sh[j] >= {1'b0, pt_ff[j+1].frame_count});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else if (state_ff == ST_CHECK) begin
         div_busy_ff <= 1'b1;
      end else if (div_busy_ff && dcnt_ff == DCW'(DW - 1)) begin
         div_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CHECK) begin
         dcnt_ff <= '0;
         for (int j = 0; j < 2; j++) begin
            dnum_ff[j] <= DW'(UNIT) + DW'(pt_ff[j+1].frame_count >> 1);
            drem_ff[j] <= '0;
            dq_ff[j]   <= '0;
         end
      end else if (div_busy_ff) begin
         dcnt_ff <= dcnt_ff + DCW'(1);
         for (int j = 0; j < 2; j++) begin
            dnum_ff[j] <= dnum_ff[j] << 1;
            drem_ff[j] <= rem_ge[j] ? rem_sh[j] - {1'b0, pt_ff[j+1].frame_count}
                                    : rem_sh[j];
            dq_ff[j]   <= {dq_ff[j][DW-2:0], rem_ge[j]};
         end
      end
   end

   // response register
   logic rsp_load;
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_x_ff     <= res_x_ff;
         rsp_y_ff     <= res_y_ff;
         rsp_z_ff     <= res_z_ff;
         rsp_roll_ff  <= res_roll_ff;
         rsp_angle_ff <= res_angle_ff;
         rsp_pv_ff    <= res_valid_ff;
         rsp_done_ff  <= res_done_ff;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.out_x          = rsp_x_ff;
   assign rsp_ch.out_y          = rsp_y_ff;
   assign rsp_ch.out_z          = rsp_z_ff;
   assign rsp_ch.out_roll       = rsp_roll_ff;
   assign rsp_ch.out_angle      = rsp_angle_ff;
   assign rsp_ch.position_valid = rsp_pv_ff;
   assign rsp_ch.path_done      = rsp_done_ff;

endmodule
